### sv/assert_macros.svh
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, skipped while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge, skipped while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ebaf_pkg.sv
// ----------------------------------------------------------------------------
// ebaf_pkg
// Shared types and operation codes for the eight-bit ALU with flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ebaf_pkg;

  typedef enum logic [4:0] {
    FN_OR   = 5'd0,
    FN_AND  = 5'd1,
    FN_EOR  = 5'd2,
    FN_CMP  = 5'd3,
    FN_ADC  = 5'd4,
    FN_SBC  = 5'd5,
    FN_ASL  = 5'd6,
    FN_ROL  = 5'd7,
    FN_LSR  = 5'd8,
    FN_ROR  = 5'd9,
    FN_INC  = 5'd10,
    FN_DEC  = 5'd11,
    FN_CMPW = 5'd12,
    FN_ADDW = 5'd13,
    FN_SUBW = 5'd14,
    FN_INCW = 5'd15,
    FN_DECW = 5'd16,
    FN_DIV  = 5'd17,
    FN_MUL  = 5'd18,
    FN_DAA  = 5'd19,
    FN_DAS  = 5'd20,
    FN_XCN  = 5'd21
  } func_e;

  localparam int unsigned DivSteps = 9;

  // Item as it travels down the pipe
  typedef struct packed {
    logic [4:0]  func;
    logic [15:0] lw;
    logic [15:0] rw;
    logic        c;
    logic        h;
    logic        v;
  } item_t;

  // Finished result with flags, from the ALU stage or the divider
  typedef struct packed {
    logic [15:0] res;
    logic        c;
    logic        z;
    logic        n;
    logic        v;
    logic        h;
  } flags_t;

endpackage
`default_nettype wire

### sv/ebaf_alu_stage.sv
// ----------------------------------------------------------------------------
// ebaf_alu_stage
// Registered combinational operations; the multiply is pipelined over two
// registers and the other results wait alongside it, then one more register
// lines everything up with the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ebaf_alu_stage (
  input  wire                  clk_i,
  input  wire ebaf_pkg::item_t item_i,
  output ebaf_pkg::flags_t     flags_o
);

  ebaf_pkg::flags_t f_d, f1_q, f2_d, f2_q, f3_q;
  logic [15:0] prod_q;
  logic        mul1_q;

  always_comb begin
    logic [7:0]  l, r, t8;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic        big;
    l = item_i.lw[7:0];
    r = item_i.rw[7:0];
    f_d = '{res: 16'd0, c: item_i.c, z: 1'b1, n: 1'b0, v: item_i.v, h: item_i.h};
    s9 = '0; s5 = '0; s17 = '0; s13 = '0; t8 = '0; big = 1'b0;
    unique case (item_i.func)
      ebaf_pkg::FN_OR:  f_d.res = {8'd0, l | r};
      ebaf_pkg::FN_AND: f_d.res = {8'd0, l & r};
      ebaf_pkg::FN_EOR: f_d.res = {8'd0, l ^ r};
      ebaf_pkg::FN_CMP: begin
        s9 = {1'b0, l} - {1'b0, r};
        f_d.res = {8'd0, l};
        f_d.c = ~s9[8];
      end
      ebaf_pkg::FN_ADC: begin
        s9 = {1'b0, l} + {1'b0, r} + {8'd0, item_i.c};
        s5 = {1'b0, l[3:0]} + {1'b0, r[3:0]} + {4'd0, item_i.c};
        f_d.res = {8'd0, s9[7:0]};
        f_d.c = s9[8];
        f_d.h = s5[4];
        f_d.v = ~(l[7] ^ r[7]) & (l[7] ^ s9[7]);
      end
      ebaf_pkg::FN_SBC: begin
        s9 = {1'b0, l} - {1'b0, r} - {8'd0, ~item_i.c};
        s5 = {1'b0, l[3:0]} - {1'b0, r[3:0]} - {4'd0, ~item_i.c};
        f_d.res = {8'd0, s9[7:0]};
        f_d.c = ~s9[8];
        f_d.h = ~s5[4];
        f_d.v = (l[7] ^ r[7]) & (l[7] ^ s9[7]);
      end
      ebaf_pkg::FN_ASL: begin f_d.res = {8'd0, l[6:0], 1'b0}; f_d.c = l[7]; end
      ebaf_pkg::FN_ROL: begin f_d.res = {8'd0, l[6:0], item_i.c}; f_d.c = l[7]; end
      ebaf_pkg::FN_LSR: begin f_d.res = {9'd0, l[7:1]}; f_d.c = l[0]; end
      ebaf_pkg::FN_ROR: begin f_d.res = {8'd0, item_i.c, l[7:1]}; f_d.c = l[0]; end
      ebaf_pkg::FN_INC: f_d.res = {8'd0, l + 8'd1};
      ebaf_pkg::FN_DEC: f_d.res = {8'd0, l - 8'd1};
      ebaf_pkg::FN_CMPW: begin
        s17 = {1'b0, item_i.lw} - {1'b0, item_i.rw};
        f_d.res = item_i.lw;
        f_d.c = ~s17[16];
      end
      ebaf_pkg::FN_ADDW: begin
        s17 = {1'b0, item_i.lw} + {1'b0, item_i.rw};
        s13 = {1'b0, item_i.lw[11:0]} + {1'b0, item_i.rw[11:0]};
        f_d.res = s17[15:0];
        f_d.c = s17[16];
        f_d.h = s13[12];
        f_d.v = ~(item_i.lw[15] ^ item_i.rw[15]) & (item_i.lw[15] ^ s17[15]);
      end
      ebaf_pkg::FN_SUBW: begin
        s17 = {1'b0, item_i.lw} - {1'b0, item_i.rw};
        s13 = {1'b0, item_i.lw[11:0]} - {1'b0, item_i.rw[11:0]};
        f_d.res = s17[15:0];
        f_d.c = ~s17[16];
        f_d.h = ~s13[12];
        f_d.v = (item_i.lw[15] ^ item_i.rw[15]) & (item_i.lw[15] ^ s17[15]);
      end
      ebaf_pkg::FN_INCW: f_d.res = item_i.lw + 16'd1;
      ebaf_pkg::FN_DECW: f_d.res = item_i.lw - 16'd1;
      ebaf_pkg::FN_DAA: begin
        t8 = l;
        big = item_i.c | (l > 8'h99);
        if (big) begin
          t8 = t8 + 8'h60;
          f_d.c = 1'b1;
        end
        if (item_i.h | (t8[3:0] > 4'd9)) t8 = t8 + 8'd6;
        f_d.res = {8'd0, t8};
      end
      ebaf_pkg::FN_DAS: begin
        t8 = l;
        big = ~item_i.c | (l > 8'h99);
        if (big) begin
          t8 = t8 - 8'h60;
          f_d.c = 1'b0;
        end
        if (~item_i.h | (t8[3:0] > 4'd9)) t8 = t8 - 8'd6;
        f_d.res = {8'd0, t8};
      end
      ebaf_pkg::FN_XCN: f_d.res = {8'd0, l[3:0], l[7:4]};
      default: f_d.res = 16'd0;
    endcase
    // Z and N: compares flag the difference, word ops the 16-bit result, others the low byte
    priority if (item_i.func == ebaf_pkg::FN_CMP) begin
      f_d.z = (s9[7:0] == 8'd0);
      f_d.n = s9[7];
    end else if (item_i.func == ebaf_pkg::FN_CMPW) begin
      f_d.z = (s17[15:0] == 16'd0);
      f_d.n = s17[15];
    end else if (item_i.func >= ebaf_pkg::FN_CMPW && item_i.func <= ebaf_pkg::FN_DECW) begin
      f_d.z = (f_d.res == 16'd0);
      f_d.n = f_d.res[15];
    end else if (item_i.func <= ebaf_pkg::FN_XCN) begin
      f_d.z = (f_d.res[7:0] == 8'd0);
      f_d.n = f_d.res[7];
    end else begin
      f_d.z = 1'b1;
      f_d.n = 1'b0;
    end
  end

  // multiply result joins the flags in the second stage
  always_comb begin
    f2_d = f1_q;
    if (mul1_q) begin
      f2_d.res = prod_q;
      f2_d.z   = (prod_q[15:8] == 8'd0);
      f2_d.n   = prod_q[15];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= f_d;
    mul1_q <= (item_i.func == ebaf_pkg::FN_MUL);
    prod_q <= {8'd0, item_i.lw[7:0]} * {8'd0, item_i.rw[7:0]};
    f2_q   <= f2_d;
    f3_q   <= f2_q;
  end

  assign flags_o = f3_q;

endmodule
`default_nettype wire

### sv/ebaf_div_pipe.sv
// ----------------------------------------------------------------------------
// ebaf_div_pipe
// Pipelined restoring divide of YA by X, three quotient bits per stage over
// three stages, then the special-case correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ebaf_div_pipe (
  input  wire                  clk_i,
  input  wire ebaf_pkg::item_t item_i,
  output ebaf_pkg::flags_t     flags_o
);

  // Normal path: YA / X for X != 0 and Y < 2X fits 9 quotient bits.
  // Overflow path: num / (256 - X) with num = YA - 256X.
  // Both share one 16/9 divider; the operand is chosen up front.
  localparam int unsigned Stages = 3;
  localparam int unsigned PerStage = ebaf_pkg::DivSteps / Stages;

  typedef struct packed {
    logic [15:0] num;   // dividend bits still to shift in (low)
    logic [8:0]  den;
    logic [8:0]  rem;
    logic [8:0]  quo;
    logic [7:0]  x;
    logic [7:0]  a;
    logic [1:0]  mode;  // 0 normal, 1 overflow, 2 by zero
    logic        c;
    logic        h;
    logic        v;
  } dv_t;

  dv_t s_q [Stages+1];
  dv_t s0;

  always_comb begin
    logic [7:0] y, x;
    logic [15:0] n;
    y = item_i.lw[15:8];
    x = item_i.rw[7:0];
    s0 = '0;
    s0.x = x;
    s0.a = item_i.lw[7:0];
    s0.c = item_i.c;
    s0.h = (y[3:0] >= x[3:0]);
    s0.v = (y >= x);
    if (x == 8'd0) begin
      s0.mode = 2'd2;
      s0.den = 9'd1;
    end else if ({1'b0, y} < {x, 1'b0}) begin
      s0.mode = 2'd0;
      s0.den = {1'b0, x};
    end else begin
      s0.mode = 2'd1;
      s0.den = 9'd256 - {1'b0, x};
    end
    n = (s0.mode == 2'd1) ? (item_i.lw - {x, 8'd0}) : item_i.lw;
    // first 7 quotient bits are zero (quotient < 512), so preload remainder
    s0.rem = {2'b0, n[15:9]};
    s0.num = {n[8:0], 7'd0};
  end

  assign s_q[0] = s0;

  for (genvar g = 0; g < Stages; g++) begin : g_st
    dv_t nx;
    always_comb begin
      logic [9:0] tr;
      nx = s_q[g];
      for (int k = 0; k < PerStage; k++) begin
        tr = {nx.rem, nx.num[15]};
        nx.num = {nx.num[14:0], 1'b0};
        if (tr >= {1'b0, nx.den}) begin
          tr = tr - {1'b0, nx.den};
          nx.quo = {nx.quo[7:0], 1'b1};
        end else begin
          nx.quo = {nx.quo[7:0], 1'b0};
        end
        nx.rem = tr[8:0];
      end
    end
    always_ff @(posedge clk_i) s_q[g+1] <= nx;
  end

  always_comb begin
    dv_t e;
    logic [7:0] qa, ry;
    e = s_q[Stages];
    unique case (e.mode)
      2'd0: begin qa = e.quo[7:0]; ry = e.rem[7:0]; end
      2'd1: begin qa = 8'd255 - e.quo[7:0]; ry = e.x + e.rem[7:0]; end
      default: begin qa = 8'hff; ry = e.a; end
    endcase
    flags_o = '{res: {ry, qa}, c: e.c, z: (qa == 8'd0), n: qa[7], v: e.v, h: e.h};
  end

endmodule
`default_nettype wire

### sv/eight_bit_cpu_alu_flags_core.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_flags_core
// Eight-bit CPU ALU with flags, three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  in      | func_i, operands, carry/half/overflow_i   | start & !busy
//  out     | result_o and five flag outputs            | done strobe
//
// Each item passes down the vld_q valid pipe from start to done; one item per cycle.
// The pipeline depth is set by the divider, three quotient bits per stage.
// busy is always low: the pipe never stalls and the receiver cannot stall.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module eight_bit_cpu_alu_flags_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [4:0]  func_i,
  input  wire  [15:0] left_operand_i,
  input  wire  [15:0] right_operand_i,
  input  wire         carry_in_i,
  input  wire         half_in_i,
  input  wire         overflow_in_i,
  output logic        done,
  output logic [15:0] result_o,
  output logic        carry_out_o,
  output logic        zero_out_o,
  output logic        negative_out_o,
  output logic        overflow_out_o,
  output logic        half_out_o
);

  ebaf_pkg::item_t  item;
  ebaf_pkg::flags_t alu_f, div_f, sel_f;
  logic [2:0] vld_q, vld_d;
  logic [2:0] isdiv_q, isdiv_d;

  assign item = '{func: func_i, lw: left_operand_i, rw: right_operand_i,
                  c: carry_in_i, h: half_in_i, v: overflow_in_i};
  assign busy = 1'b0;

  ebaf_alu_stage u_alu (.clk_i(clk_i), .item_i(item), .flags_o(alu_f));
  ebaf_div_pipe  u_div (.clk_i(clk_i), .item_i(item), .flags_o(div_f));

  assign vld_d   = {vld_q[1:0], start};
  assign isdiv_d = {isdiv_q[1:0], func_i == ebaf_pkg::FN_DIV};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) isdiv_q <= isdiv_d;

  assign sel_f          = isdiv_q[2] ? div_f : alu_f;
  assign done           = vld_q[2];
  assign result_o       = sel_f.res;
  assign carry_out_o    = sel_f.c;
  assign zero_out_o     = sel_f.z;
  assign negative_out_o = sel_f.n;
  assign overflow_out_o = sel_f.v;
  assign half_out_o     = sel_f.h;

endmodule
`default_nettype wire

### sv/ebaf_checker.sv
// ----------------------------------------------------------------------------
// ebaf_checker
// Port-level checks of the ALU pipe timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ebaf_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start,
  input wire busy,
  input wire done
);
  `ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy, "busy raised")
  `ASSERT_IMPL(a_latency, clk_i, rst_ni, $past(start, 3) && $past(rst_ni, 3), done, "done missing")
  `ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, done, $past(start, 3), "done without start")
endmodule

bind eight_bit_cpu_alu_flags_core ebaf_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done(done)
);
`default_nettype wire

### test/eight_bit_cpu_alu_flags_core_test.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_flags_core_test
// Drives directed and random ALU operations through the pipelined core and
// compares every result and flag against a behavioral ALU model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module eight_bit_cpu_alu_flags_core_test;

  localparam int unsigned PipeDepth = 3;
  localparam logic [4:0] FnLastUsed = ebaf_pkg::FN_XCN;

  typedef struct packed {
    logic [15:0] res;
    logic        c;
    logic        z;
    logic        n;
    logic        v;
    logic        h;
  } alu_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  func_i = '0;
  logic [15:0] left_operand_i = '0;
  logic [15:0] right_operand_i = '0;
  logic        carry_in_i = 1'b0;
  logic        half_in_i = 1'b0;
  logic        overflow_in_i = 1'b0;
  logic        done;
  logic [15:0] result_o;
  logic        carry_out_o, zero_out_o, negative_out_o, overflow_out_o, half_out_o;

  alu_out_t    alu_expected_q[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;

  eight_bit_cpu_alu_flags_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .left_operand_i  (left_operand_i),
    .right_operand_i (right_operand_i),
    .carry_in_i      (carry_in_i),
    .half_in_i       (half_in_i),
    .overflow_in_i   (overflow_in_i),
    .done            (done),
    .result_o        (result_o),
    .carry_out_o     (carry_out_o),
    .zero_out_o      (zero_out_o),
    .negative_out_o  (negative_out_o),
    .overflow_out_o  (overflow_out_o),
    .half_out_o      (half_out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void set_nz8(inout alu_out_t o, input logic [7:0] b);
    o.z = (b == 8'h00);
    o.n = b[7];
  endfunction

  function automatic void set_nz16(inout alu_out_t o, input logic [15:0] w);
    o.z = (w == 16'h0000);
    o.n = w[15];
  endfunction

  function automatic alu_out_t alu_predict(logic [4:0] fn, logic [15:0] lw, logic [15:0] rw,
                                           logic c, logic h, logic v);
    alu_out_t    o;
    logic [7:0]  a, b, y, q, rem, dv;
    logic [8:0]  s9;
    logic [16:0] s17;
    logic [15:0] num;
    int unsigned den;
    a = lw[7:0];
    b = rw[7:0];
    o = '{res: 16'h0, c: c, z: 1'b1, n: 1'b0, v: v, h: h};
    case (fn)
      ebaf_pkg::FN_OR: begin o.res = {8'h0, a | b}; set_nz8(o, a | b); end
      ebaf_pkg::FN_AND: begin o.res = {8'h0, a & b}; set_nz8(o, a & b); end
      ebaf_pkg::FN_EOR: begin o.res = {8'h0, a ^ b}; set_nz8(o, a ^ b); end
      ebaf_pkg::FN_CMP: begin o.res = {8'h0, a}; o.c = (a >= b); set_nz8(o, a - b); end
      ebaf_pkg::FN_ADC: begin
        s9 = {1'b0, a} + {1'b0, b} + {8'd0, c};
        o.c = s9[8];
        o.h = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c}) > 5'd15;
        o.v = ~(a[7] ^ b[7]) & (a[7] ^ s9[7]);
        o.res = {8'h0, s9[7:0]};
        set_nz8(o, s9[7:0]);
      end
      ebaf_pkg::FN_SBC: begin
        s9 = {1'b0, a} - {1'b0, b} - {8'd0, ~c};
        o.c = ({1'b0, a} >= {1'b0, b} + {8'd0, ~c});
        o.h = ({1'b0, a[3:0]} >= {1'b0, b[3:0]} + {4'd0, ~c});
        o.v = (a[7] ^ b[7]) & (a[7] ^ s9[7]);
        o.res = {8'h0, s9[7:0]};
        set_nz8(o, s9[7:0]);
      end
      ebaf_pkg::FN_ASL: begin
        o.c = a[7]; o.res = {8'h0, a[6:0], 1'b0}; set_nz8(o, o.res[7:0]);
      end
      ebaf_pkg::FN_ROL: begin
        o.c = a[7]; o.res = {8'h0, a[6:0], c}; set_nz8(o, o.res[7:0]);
      end
      ebaf_pkg::FN_LSR: begin
        o.c = a[0]; o.res = {9'h0, a[7:1]}; set_nz8(o, o.res[7:0]);
      end
      ebaf_pkg::FN_ROR: begin
        o.c = a[0]; o.res = {8'h0, c, a[7:1]}; set_nz8(o, o.res[7:0]);
      end
      ebaf_pkg::FN_INC: begin o.res = {8'h0, a + 8'd1}; set_nz8(o, o.res[7:0]); end
      ebaf_pkg::FN_DEC: begin o.res = {8'h0, a - 8'd1}; set_nz8(o, o.res[7:0]); end
      ebaf_pkg::FN_CMPW: begin o.res = lw; o.c = (lw >= rw); set_nz16(o, lw - rw); end
      ebaf_pkg::FN_ADDW: begin
        s17 = {1'b0, lw} + {1'b0, rw};
        o.c = s17[16];
        o.h = ({1'b0, lw[11:0]} + {1'b0, rw[11:0]}) > 13'h0fff;
        o.v = ~(lw[15] ^ rw[15]) & (lw[15] ^ s17[15]);
        o.res = s17[15:0];
        set_nz16(o, o.res);
      end
      ebaf_pkg::FN_SUBW: begin
        s17 = {1'b0, lw} - {1'b0, rw};
        o.c = (lw >= rw);
        o.h = (lw[11:0] >= rw[11:0]);
        o.v = (lw[15] ^ rw[15]) & (lw[15] ^ s17[15]);
        o.res = s17[15:0];
        set_nz16(o, o.res);
      end
      ebaf_pkg::FN_INCW: begin o.res = lw + 16'd1; set_nz16(o, o.res); end
      ebaf_pkg::FN_DECW: begin o.res = lw - 16'd1; set_nz16(o, o.res); end
      ebaf_pkg::FN_DIV: begin
        y = lw[15:8];
        dv = b;
        o.h = (y[3:0] >= dv[3:0]);
        o.v = (y >= dv);
        if (dv == 8'h00) begin
          q = 8'hff;
          rem = a;
        end else if ({1'b0, y} < {dv, 1'b0}) begin
          q = 8'(lw / dv);
          rem = 8'(lw % dv);
        end else begin
          // quotient would not fit: the hardware's wrapped rule
          den = 256 - dv;
          num = lw - {dv, 8'h00};
          q = 8'(255 - num / den);
          rem = 8'(dv + num % den);
        end
        o.res = {rem, q};
        set_nz8(o, q);
      end
      ebaf_pkg::FN_MUL: begin
        o.res = {8'h0, a} * {8'h0, b}; set_nz8(o, o.res[15:8]);
      end
      ebaf_pkg::FN_DAA: begin
        y = a;
        if (c || y > 8'h99) begin y = y + 8'h60; o.c = 1'b1; end
        if (h || y[3:0] > 4'd9) y = y + 8'h06;
        o.res = {8'h0, y};
        set_nz8(o, y);
      end
      ebaf_pkg::FN_DAS: begin
        y = a;
        if (!c || y > 8'h99) begin y = y - 8'h60; o.c = 1'b0; end
        if (!h || y[3:0] > 4'd9) y = y - 8'h06;
        o.res = {8'h0, y};
        set_nz8(o, y);
      end
      ebaf_pkg::FN_XCN: begin
        o.res = {8'h0, a[3:0], a[7:4]}; set_nz8(o, o.res[7:0]);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic issue_op(logic [4:0] fn, logic [15:0] lw, logic [15:0] rw,
                          logic c, logic h, logic v);
    start <= 1'b1;
    func_i <= fn;
    left_operand_i <= lw;
    right_operand_i <= rw;
    carry_in_i <= c;
    half_in_i <= h;
    overflow_in_i <= v;
    do @(posedge clk_i); while (busy);
    alu_expected_q.push_back(alu_predict(fn, lw, rw, c, h, v));
    n_sent++;
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (alu_expected_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // result checker: done marks a valid result, sampled at the edge
  always @(posedge clk_i) begin
    alu_out_t exp_o;
    if (rst_ni && done) begin
      if (alu_expected_q.size() == 0) begin
        $error("unexpected transaction: result %h", result_o);
        n_errors++;
      end else begin
        exp_o = alu_expected_q.pop_front();
        n_checked++;
        if (result_o !== exp_o.res) begin
          $error("result: expected %h actual %h", exp_o.res, result_o); n_errors++;
        end
        if (carry_out_o !== exp_o.c) begin
          $error("carry_out: expected %b actual %b", exp_o.c, carry_out_o); n_errors++;
        end
        if (zero_out_o !== exp_o.z) begin
          $error("zero_out: expected %b actual %b", exp_o.z, zero_out_o); n_errors++;
        end
        if (negative_out_o !== exp_o.n) begin
          $error("negative_out: expected %b actual %b", exp_o.n, negative_out_o); n_errors++;
        end
        if (overflow_out_o !== exp_o.v) begin
          $error("overflow_out: expected %b actual %b", exp_o.v, overflow_out_o); n_errors++;
        end
        if (half_out_o !== exp_o.h) begin
          $error("half_out: expected %b actual %b", exp_o.h, half_out_o); n_errors++;
        end
      end
    end
  end

  task automatic test_operand_extremes();
    issue_op(ebaf_pkg::FN_ADC, 16'hff7f, 16'hff01, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_ADC, 16'h00ff, 16'h00ff, 1'b1, 1'b0, 1'b1);
    issue_op(ebaf_pkg::FN_SBC, 16'h0000, 16'h0001, 1'b0, 1'b1, 1'b0);
    issue_op(ebaf_pkg::FN_SBC, 16'h0080, 16'h0001, 1'b1, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_ADDW, 16'hffff, 16'h0001, 1'b1, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_ADDW, 16'h7fff, 16'h0fff, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_SUBW, 16'h0000, 16'hffff, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_CMPW, 16'h8000, 16'h8000, 1'b0, 1'b1, 1'b1);
    issue_op(ebaf_pkg::FN_INCW, 16'hffff, 16'h0000, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_DECW, 16'h0000, 16'hffff, 1'b1, 1'b1, 1'b1);
    issue_op(ebaf_pkg::FN_MUL, 16'h00ff, 16'h00ff, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_DAA, 16'h009a, 16'h0000, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_DAS, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_divide_cases();
    issue_op(ebaf_pkg::FN_DIV, 16'h1234, 16'h0000, 1'b0, 1'b0, 1'b0);  // divide by zero
    issue_op(ebaf_pkg::FN_DIV, 16'hff00, 16'h0001, 1'b0, 1'b0, 1'b0);  // quotient overflow
    issue_op(ebaf_pkg::FN_DIV, 16'hffff, 16'h00ff, 1'b0, 1'b0, 1'b0);
    issue_op(ebaf_pkg::FN_DIV, 16'h0100, 16'h0003, 1'b1, 1'b1, 1'b1);
    issue_op(ebaf_pkg::FN_DIV, 16'h0f10, 16'h0008, 1'b0, 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_every_code();
    for (int f = 0; f < 32; f++) begin
      issue_op(5'(f), 16'(($urandom)), 16'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom));
      issue_op(5'(f), 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1);
    end
    drain_results();
  endtask

  task automatic test_random_bursts(int unsigned n_items);
    int unsigned i, burst;
    logic [4:0]  fn;
    logic [15:0] lw, rw;
    i = 0;
    while (i < n_items) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && i < n_items; k++) begin
        // mostly defined operations, some unused codes
        fn = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(22, 31))
                                          : 5'($urandom_range(0, FnLastUsed));
        lw = 16'($urandom);
        rw = 16'($urandom);
        if (fn == ebaf_pkg::FN_DIV && $urandom_range(0, 3) == 0) begin
          rw[7:0] = 8'($urandom_range(0, 3));
        end
        issue_op(fn, lw, rw, 1'($urandom), 1'($urandom), 1'($urandom));
        i++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      if ($urandom_range(0, 60) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_operand_extremes();
    test_divide_cases();
    test_every_code();
    test_random_bursts(850);
    $display("Ran %0d transactions, %0d checked: all codes, flag extremes, divide rules.",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/ebaf_pkg.sv
sv/ebaf_alu_stage.sv
sv/ebaf_div_pipe.sv
sv/eight_bit_cpu_alu_flags_core.sv
sv/ebaf_checker.sv
test/eight_bit_cpu_alu_flags_core_test.sv
